/* sv/tnes_pkg.sv */
// Package with payload types, codes and constants of the note event sequencer.
`timescale 1ns / 1ps
package tnes_pkg;
   localparam int MaxEvents = 1024;
   localparam int NoteSlots = 128;
   localparam int IdxW = $clog2(MaxEvents);
   localparam int CntW = IdxW + 1;
   localparam int EntryW = 41;

   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_TOGGLE = 3'd1;
   localparam logic [2:0] OP_RESTART = 3'd2;
   localparam logic [2:0] OP_SEEK = 3'd3;
   localparam logic [2:0] OP_LOAD = 3'd4;

   localparam logic [1:0] MODE_STOPPED = 2'd0;
   localparam logic [1:0] MODE_PLAYING = 2'd1;
   localparam logic [1:0] MODE_PAUSED = 2'd2;

   typedef struct packed {
      logic [2:0] operation;
      logic [31:0] now_ms;
      logic signed [31:0] seek_delta_ms;
      logic [9:0] entry_index;
      logic [31:0] entry_time_ms;
      logic [7:0] entry_note;
      logic entry_on;
   } req_type;

   typedef struct packed {
      logic [63:0] active_low;
      logic [63:0] active_high;
      logic [1:0] play_state;
      logic [31:0] position_ms;
   } rsp_type;
endpackage

/* sv/tnes_ram.sv */
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module tnes_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* sv/timed_note_event_sequencer_unit.sv */
// Top level: operation sequencer, event table and note map of the sequencer.
// A load, a toggle without restart, a tick while not playing and unused codes go
// straight to S_DONE; a walking tick, restart, seek or restarting toggle walks the
// table through S_READ, S_WAIT and S_CHECK for each event applied, skipping S_WAIT
// when the walk reaches the table end, since the table read is registered.
// One word is handled at a time; a finished result waits in the output register.
// Synchronous active-high reset clears the playback state and note map; the
// event table holds nothing defined until written.
`timescale 1ns / 1ps
module timed_note_event_sequencer_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  tnes_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tnes_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [10:0] csr_wr_data
);
   typedef enum logic [2:0] {S_IDLE, S_READ, S_WAIT, S_CHECK, S_DONE} state_type;

   state_type state_ff, state_in;
   logic [tnes_pkg::CntW-1:0] next_ff, next_in;
   logic [31:0] pos_ff, pos_in, last_ff, last_in, len_ff, len_in, target_ff, target_in;
   logic [1:0] mode_ff, mode_in;
   logic [127:0] notes_ff, notes_in;
   logic [10:0] total_ff;
   logic [2:0] op_ff, op_in;
   logic rsp_valid_ff, rsp_valid_in;
   tnes_pkg::rsp_type rsp_ff, rsp_in;

   logic wr_en;
   logic [tnes_pkg::EntryW-1:0] rd_data;
   logic [tnes_pkg::CntW-1:0] cnt;
   logic [31:0] delta, len_sel;
   logic [32:0] sum;
   logic signed [33:0] seek_t;
   logic [31:0] e_time;
   logic [7:0] e_note;
   logic e_on;

   // Event table: time, note, on.
   assign wr_en = (state_ff == S_IDLE) && req_valid && !req_stall &&
                  (req_data.operation == tnes_pkg::OP_LOAD);
   tnes_ram #(.Width(tnes_pkg::EntryW), .Depth(tnes_pkg::MaxEvents)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(req_data.entry_index[tnes_pkg::IdxW-1:0]),
      .wr_data({req_data.entry_time_ms, req_data.entry_note, req_data.entry_on}),
      .rd_addr(next_ff[tnes_pkg::IdxW-1:0]), .rd_data(rd_data));
   assign {e_time, e_note, e_on} = rd_data;

   assign cnt = (total_ff > 11'(tnes_pkg::MaxEvents)) ? tnes_pkg::CntW'(tnes_pkg::MaxEvents)
                                                       : tnes_pkg::CntW'(total_ff);
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign len_sel = len_ff;

   // Sequencer: accepts a word, walks due events, then posts the result.
   always_comb begin
      state_in = state_ff; next_in = next_ff; pos_in = pos_ff; last_in = last_ff;
      len_in = len_ff; mode_in = mode_ff; notes_in = notes_ff; op_in = op_ff;
      target_in = target_ff; rsp_valid_in = rsp_valid_ff && rsp_stall; rsp_in = rsp_ff;
      delta = 32'd0; sum = 33'd0; seek_t = 34'sd0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in = req_data.operation;
               state_in = S_DONE;
               case (req_data.operation)
                  tnes_pkg::OP_TICK: begin
                     last_in = req_data.now_ms;
                     if (mode_ff == tnes_pkg::MODE_PLAYING) begin
                        delta = (last_ff == 32'd0) ? 32'd0 : req_data.now_ms - last_ff;
                        sum = {1'b0, pos_ff} + {1'b0, delta};
                        target_in = (sum >= {1'b0, len_sel}) ? len_sel : sum[31:0];
                        state_in = S_READ;
                     end
                  end
                  tnes_pkg::OP_TOGGLE: begin
                     if (mode_ff == tnes_pkg::MODE_PLAYING) begin
                        mode_in = tnes_pkg::MODE_PAUSED;
                     end else begin
                        mode_in = tnes_pkg::MODE_PLAYING;
                        last_in = 32'd0;
                        if (mode_ff == tnes_pkg::MODE_STOPPED && pos_ff >= len_ff) begin
                           notes_in = '0; next_in = '0; target_in = 32'd0;
                           state_in = S_READ;
                        end
                     end
                  end
                  tnes_pkg::OP_RESTART: begin
                     mode_in = tnes_pkg::MODE_STOPPED; last_in = 32'd0;
                     notes_in = '0; next_in = '0; target_in = 32'd0; state_in = S_READ;
                  end
                  tnes_pkg::OP_SEEK: begin
                     seek_t = $signed({2'b00, pos_ff}) + 34'(req_data.seek_delta_ms);
                     if (seek_t < 0) target_in = 32'd0;
                     else if (seek_t > $signed({2'b00, len_ff})) target_in = len_ff;
                     else target_in = seek_t[31:0];
                     last_in = 32'd0; notes_in = '0; next_in = '0; state_in = S_READ;
                  end
                  tnes_pkg::OP_LOAD: begin
                     if (total_ff != 11'd0 && {1'b0, req_data.entry_index} == total_ff - 11'd1)
                        len_in = req_data.entry_time_ms;
                     mode_in = tnes_pkg::MODE_STOPPED; pos_in = 32'd0; last_in = 32'd0;
                     next_in = '0; notes_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // Read address is next_ff; data arrives next cycle.
            state_in = (next_ff < cnt) ? S_WAIT : S_CHECK;
         end
         S_WAIT: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (next_ff < cnt && e_time <= target_ff) begin
               if (e_note < 8'(tnes_pkg::NoteSlots)) notes_in[e_note[6:0]] = e_on;
               next_in = next_ff + 1'b1;
               state_in = S_READ;
            end else begin
               pos_in = target_ff;
               state_in = S_DONE;
               if (op_ff == tnes_pkg::OP_TICK && target_ff >= len_ff) begin
                  mode_in = tnes_pkg::MODE_STOPPED; notes_in = '0;
               end
               if (op_ff == tnes_pkg::OP_SEEK && mode_ff == tnes_pkg::MODE_STOPPED &&
                   target_ff < len_ff) notes_in = '0;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{active_low: notes_ff[63:0], active_high: notes_ff[127:64],
                       play_state: mode_ff, position_ms: pos_ff};
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; next_ff <= '0; pos_ff <= '0; last_ff <= '0; len_ff <= '0;
         mode_ff <= tnes_pkg::MODE_STOPPED; notes_ff <= '0; total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; next_ff <= next_in; pos_ff <= pos_in; last_ff <= last_in;
         len_ff <= len_in; mode_ff <= mode_in; notes_ff <= notes_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) total_ff <= csr_wr_data;
      end
      op_ff <= op_in; target_ff <= target_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
